[sv/button_debounce_long_press_stepper_assert.svh]
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_STEPPER_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_STEPPER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdlp check failed");

// Next-cycle implication, off while reset is asserted
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdlp check failed");

`endif

[sv/bdlp_pkg.sv]
`default_nettype none

package bdlp_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Press phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DEB   = 2'd1;
    localparam logic [1:0] PH_SHORT = 2'd2;
    localparam logic [1:0] PH_LONG  = 2'd3;

    // Step direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_INC  = 2'd1;
    localparam logic [1:0] DIR_DEC  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DIRECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE    = 3'd6;

    // Stepper settings handed to the step unit
    typedef struct packed {
        logic [1:0]         step_direction;
        logic [VALUE_W-1:0] value_max;
        logic [VALUE_W-1:0] step_size;
        logic               wrap_enable;
    } step_cfg_t;

endpackage

`default_nettype wire

[sv/bdlp_step.sv]
`default_nettype none

// Value stepper: one add or subtract with wrap or clamp at the limits
module bdlp_step (
    input  wire bdlp_pkg::step_cfg_t              cfg,
    input  wire                                   fire,
    input  wire logic [bdlp_pkg::VALUE_W-1:0]     value,
    output logic      [bdlp_pkg::VALUE_W-1:0]     new_value,
    output logic                                  changed
);

    logic [bdlp_pkg::VALUE_W:0]   sum;
    logic [bdlp_pkg::VALUE_W-1:0] inc_value;
    logic [bdlp_pkg::VALUE_W-1:0] dec_value;

    // Increment at full width, then limit check
    assign sum = {1'b0, value} + {1'b0, cfg.step_size};

    always_comb
    begin
        if (sum > {1'b0, cfg.value_max})
            inc_value = cfg.wrap_enable ? '0 : cfg.value_max;
        else
            inc_value = sum[bdlp_pkg::VALUE_W-1:0];
    end

    // Decrement clamps at zero; zero itself wraps to the maximum if enabled
    always_comb
    begin
        if (value != '0)
            dec_value = (value >= cfg.step_size) ? (value - cfg.step_size) : '0;
        else
            dec_value = cfg.wrap_enable ? cfg.value_max : '0;
    end

    always_comb
    begin
        new_value = value;
        changed   = 1'b0;
        if (fire)
        begin
            unique case (cfg.step_direction)
                bdlp_pkg::DIR_INC:
                begin
                    new_value = inc_value;
                    changed   = 1'b1;
                end
                bdlp_pkg::DIR_DEC:
                begin
                    new_value = dec_value;
                    changed   = 1'b1;
                end
                default:
                begin
                    new_value = value;
                    changed   = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/button_debounce_long_press_stepper.sv]
// A request accepted into the input register moves on to the result register,
// which then holds its result on the outputs.
// Throughput: one request per cycle when not stalled; the press state updates
// as each request leaves the input register, so requests run back to back.
// Reset (rst_n low, asynchronous): press machine idle, counter and flags
// cleared, stepper armed, both pipeline stages empty, registers at defaults.
`default_nettype none

module button_debounce_long_press_stepper (
    input  wire                                    clk,
    input  wire                                    rst_n,
    // Request channel
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    pin_level,
    input  wire logic [bdlp_pkg::VALUE_W-1:0]      current_value,
    // Result channel
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic                                   short_press,
    output logic                                   long_press,
    output logic      [bdlp_pkg::VALUE_W-1:0]      new_value,
    output logic                                   value_changed,
    // Configuration
    input  wire                                    cfg_we,
    input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers
    logic                           active_low_reg;
    logic [bdlp_pkg::VALUE_W-1:0]   debounce_ticks_reg;
    logic [bdlp_pkg::VALUE_W-1:0]   long_ticks_reg;
    bdlp_pkg::step_cfg_t            step_cfg_reg;

    // Input stage
    logic                           s1_valid_reg;
    logic                           s1_pin_reg;
    logic [bdlp_pkg::VALUE_W-1:0]   s1_value_reg;

    // Press state
    logic [1:0]                     phase_reg, phase_next;
    logic [bdlp_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                           short_reg, short_next;
    logic                           long_reg, long_next;
    logic                           wait_reg, wait_next;

    // Result stage
    logic                           out_valid_reg;
    logic                           out_short_reg;
    logic                           out_long_reg;
    logic [bdlp_pkg::VALUE_W-1:0]   out_value_reg;
    logic                           out_changed_reg;

    logic                           out_adv;
    logic                           s1_adv;
    logic                           in_take;
    logic                           pressed;
    logic [bdlp_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                           step_fire;
    logic [bdlp_pkg::VALUE_W-1:0]   step_value;
    logic                           step_changed;

    // Handshake: result register frees when empty or taken
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_take  = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg              <= 1'b0;
            debounce_ticks_reg          <= 16'd50;
            long_ticks_reg              <= 16'd1000;
            step_cfg_reg.step_direction <= bdlp_pkg::DIR_NONE;
            step_cfg_reg.value_max      <= 16'hFFFF;
            step_cfg_reg.step_size      <= 16'd1;
            step_cfg_reg.wrap_enable    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdlp_pkg::REG_ACTIVE_LOW:     active_low_reg <= cfg_data[0];
                bdlp_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                bdlp_pkg::REG_LONG_TICKS:     long_ticks_reg <= cfg_data;
                bdlp_pkg::REG_STEP_DIRECTION: step_cfg_reg.step_direction <= cfg_data[1:0];
                bdlp_pkg::REG_VALUE_MAX:      step_cfg_reg.value_max <= cfg_data;
                bdlp_pkg::REG_STEP_SIZE:      step_cfg_reg.step_size <= cfg_data;
                bdlp_pkg::REG_WRAP_ENABLE:    step_cfg_reg.wrap_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (out_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pin_reg   <= pin_level;
            s1_value_reg <= current_value;
        end
    end

    // Press phase machine
    assign pressed     = active_low_reg ? !s1_pin_reg : s1_pin_reg;
    assign elapsed_inc = (elapsed_reg == bdlp_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                : elapsed_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        short_next   = short_reg;
        long_next    = long_reg;
        if (!pressed)
        begin
            phase_next = bdlp_pkg::PH_IDLE;
            short_next = 1'b0;
            long_next  = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                bdlp_pkg::PH_IDLE:
                begin
                    short_next   = 1'b0;
                    long_next    = 1'b0;
                    elapsed_next = '0;
                    phase_next   = bdlp_pkg::PH_DEB;
                end
                bdlp_pkg::PH_DEB:
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, debounce_ticks_reg})
                    begin
                        short_next   = 1'b1;
                        elapsed_next = '0;
                        phase_next   = bdlp_pkg::PH_SHORT;
                    end
                end
                bdlp_pkg::PH_SHORT:
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, long_ticks_reg})
                    begin
                        long_next  = 1'b1;
                        phase_next = bdlp_pkg::PH_LONG;
                    end
                end
                bdlp_pkg::PH_LONG:
                begin
                    phase_next = bdlp_pkg::PH_LONG;
                end
                default:
                begin
                    phase_next = bdlp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Stepper arming: one step on the first tick with the short flag set,
    // rearmed once the flag drops
    assign step_fire = !wait_reg && short_next;
    assign wait_next = short_next;

    bdlp_step u_step (
        .cfg       (step_cfg_reg),
        .fire      (step_fire),
        .value     (s1_value_reg),
        .new_value (step_value),
        .changed   (step_changed)
    );

    // State update as each request leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bdlp_pkg::PH_IDLE;
            elapsed_reg <= '0;
            short_reg   <= 1'b0;
            long_reg    <= 1'b0;
            wait_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            short_reg   <= short_next;
            long_reg    <= long_next;
            wait_reg    <= wait_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_short_reg   <= short_next;
            out_long_reg    <= long_next;
            out_value_reg   <= step_value;
            out_changed_reg <= step_changed;
        end
    end

    assign out_valid     = out_valid_reg;
    assign short_press   = out_short_reg;
    assign long_press    = out_long_reg;
    assign new_value     = out_value_reg;
    assign value_changed = out_changed_reg;

endmodule

`default_nettype wire

[sv/bdlp_checker.sv]
`default_nettype none

`include "button_debounce_long_press_stepper_assert.svh"

// Port-level checks on the debounce block
module bdlp_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  in_valid,
    input wire                                  in_stall,
    input wire                                  out_valid,
    input wire                                  out_stall,
    input wire                                  short_press,
    input wire                                  long_press,
    input wire logic [bdlp_pkg::VALUE_W-1:0]    new_value,
    input wire                                  value_changed
);

    // A long press is always also a short press
    `BDLP_ASSERT_NOW(a_long_implies_short, clk, rst_n, out_valid && long_press, short_press)

    // A step is only taken while the short flag is up
    `BDLP_ASSERT_NOW(a_step_needs_short, clk, rst_n, out_valid && value_changed, short_press)

    // Once past the input register, an accepted request has a result
    `BDLP_ASSERT_NOW(a_result_latency, clk, rst_n,
        $past(rst_n, 2) && $past(rst_n) && $past(in_valid && !in_stall, 2), out_valid)

    // A stalled result holds
    `BDLP_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(new_value) && $stable(short_press) && $stable(value_changed))

endmodule

bind button_debounce_long_press_stepper bdlp_checker u_bdlp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .short_press   (short_press),
    .long_press    (long_press),
    .new_value     (new_value),
    .value_changed (value_changed)
);

`default_nettype wire

[tb/sv/button_debounce_long_press_stepper_tb.sv]
module button_debounce_long_press_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT     = 13;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned DRAIN_PAUSE  = 4;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PRINT_LIMIT  = 40;
    // Spare direction code, must behave as no stepping
    localparam logic [1:0]  DIR_UNUSED   = 2'd3;

    typedef logic [bdlp_pkg::VALUE_W-1:0]    value_t;
    typedef logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct {
        logic   short_press;
        logic   long_press;
        value_t new_value;
        logic   value_changed;
    } press_result_t;

    typedef struct {
        logic        act_low;
        logic [15:0] deb_ticks;
        logic [15:0] hold_ticks;
        logic [1:0]  direction;
        value_t      max_value;
        value_t      step_amt;
        logic        wrap;
    } button_cfg_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  pin_level     = 1'b0;
    value_t                current_value = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  short_press;
    logic                  long_press;
    value_t                new_value;
    logic                  value_changed;
    logic                  cfg_we        = 1'b0;
    cfg_idx_t              cfg_index     = '0;
    cfg_data_t             cfg_data      = '0;

    // Predicted press machine and stepper state
    logic [1:0]                     phase_m   = bdlp_pkg::PH_IDLE;
    logic [bdlp_pkg::ELAPSED_W-1:0] elapsed_m = '0;
    logic                           short_m   = 1'b0;
    logic                           long_m    = 1'b0;
    logic                           stepped_m = 1'b0;
    button_cfg_t                    live_cfg;

    press_result_t         pending_q[$];
    int unsigned           error_count = 0;
    int unsigned           items_sent  = 0;
    int unsigned           results_seen = 0;
    int unsigned           idle_cycles = 0;
    bit                    steady      = 1'b0;

    button_debounce_long_press_stepper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pin_level     (pin_level),
        .current_value (current_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .short_press   (short_press),
        .long_press    (long_press),
        .new_value     (new_value),
        .value_changed (value_changed),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Prints one line per mismatch (up to a cap) and counts every one
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] result %0d: %s expected %0h got %0h",
                     $time, results_seen, what, want, got);
        error_count++;
    endtask

    function automatic button_cfg_t make_cfg(input logic act_low, input logic [15:0] deb,
                                             input logic [15:0] hold, input logic [1:0] dir,
                                             input value_t max_value,
                                             input value_t step_amt,
                                             input logic wrap);
        button_cfg_t c;
        c.act_low    = act_low;
        c.deb_ticks  = deb;
        c.hold_ticks = hold;
        c.direction  = dir;
        c.max_value  = max_value;
        c.step_amt   = step_amt;
        c.wrap       = wrap;
        return c;
    endfunction

    function automatic cfg_data_t reg_word(input button_cfg_t s, input cfg_idx_t idx);
        case (idx)
            bdlp_pkg::REG_ACTIVE_LOW:     return cfg_data_t'(s.act_low);
            bdlp_pkg::REG_DEBOUNCE_TICKS: return cfg_data_t'(s.deb_ticks);
            bdlp_pkg::REG_LONG_TICKS:     return cfg_data_t'(s.hold_ticks);
            bdlp_pkg::REG_STEP_DIRECTION: return cfg_data_t'(s.direction);
            bdlp_pkg::REG_VALUE_MAX:      return cfg_data_t'(s.max_value);
            bdlp_pkg::REG_STEP_SIZE:      return cfg_data_t'(s.step_amt);
            bdlp_pkg::REG_WRAP_ENABLE:    return cfg_data_t'(s.wrap);
            default:                      return '0;
        endcase
    endfunction

    // Release: back to idle, both flags dropped on the same tick
    function automatic void drop_press();
        phase_m = bdlp_pkg::PH_IDLE;
        short_m = 1'b0;
        long_m  = 1'b0;
    endfunction

    function automatic void bump_elapsed();
        if (elapsed_m != bdlp_pkg::ELAPSED_MAX)
            elapsed_m++;
    endfunction

    // One tick of the press machine, then the stepper on the new short flag
    function automatic press_result_t predict_tick(input logic pin, input value_t val);
        press_result_t                r;
        logic                         held;
        logic [bdlp_pkg::VALUE_W:0]   sum;
        held            = live_cfg.act_low ? !pin : pin;
        r.new_value     = val;
        r.value_changed = 1'b0;

        case (phase_m)
            bdlp_pkg::PH_IDLE:
            begin
                short_m = 1'b0;
                long_m  = 1'b0;
                if (held)
                begin
                    elapsed_m = '0;
                    phase_m   = bdlp_pkg::PH_DEB;
                end
            end
            bdlp_pkg::PH_DEB:
            begin
                if (!held)
                    drop_press();
                else
                begin
                    bump_elapsed();
                    if (elapsed_m > {1'b0, live_cfg.deb_ticks})
                    begin
                        short_m   = 1'b1;
                        elapsed_m = '0;
                        phase_m   = bdlp_pkg::PH_SHORT;
                    end
                end
            end
            bdlp_pkg::PH_SHORT:
            begin
                if (!held)
                    drop_press();
                else
                begin
                    bump_elapsed();
                    if (elapsed_m > {1'b0, live_cfg.hold_ticks})
                    begin
                        long_m  = 1'b1;
                        phase_m = bdlp_pkg::PH_LONG;
                    end
                end
            end
            default:
            begin
                if (!held)
                    drop_press();
            end
        endcase

        // One step per press; rearm once the short flag is clear
        if (!stepped_m)
        begin
            if (short_m)
            begin
                if (live_cfg.direction == bdlp_pkg::DIR_INC)
                begin
                    sum = {1'b0, val} + {1'b0, live_cfg.step_amt};
                    if (sum > {1'b0, live_cfg.max_value})
                        r.new_value = live_cfg.wrap ? '0 : live_cfg.max_value;
                    else
                        r.new_value = sum[bdlp_pkg::VALUE_W-1:0];
                    r.value_changed = 1'b1;
                end
                else if (live_cfg.direction == bdlp_pkg::DIR_DEC)
                begin
                    if (val != '0)
                        r.new_value = (val >= live_cfg.step_amt) ? val - live_cfg.step_amt
                                                                 : '0;
                    else if (live_cfg.wrap)
                        r.new_value = live_cfg.max_value;
                    r.value_changed = 1'b1;
                end
                stepped_m = 1'b1;
            end
        end
        else if (!short_m)
            stepped_m = 1'b0;

        r.short_press = short_m;
        r.long_press  = long_m;
        return r;
    endfunction

    // Sends one request; entered and left at a falling edge
    task automatic send_request(input logic pin, input value_t val);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        pin_level     <= pin;
        current_value <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_q.push_back(predict_tick(pin, val));
        items_sent++;
        @(negedge clk);
    endtask

    // Stops requests and lets the pipeline empty before register writes
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(input button_cfg_t s);
        wait_for_results();
        for (int i = bdlp_pkg::REG_ACTIVE_LOW; i <= bdlp_pkg::REG_WRAP_ENABLE; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= reg_word(s, cfg_idx_t'(i));
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        live_cfg = s;
    endtask

    function automatic value_t pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return value_t'(1);
            2:       return '1;
            3:       return value_t'($urandom_range(2, 40));
            default: return value_t'($urandom());
        endcase
    endfunction

    // Values biased towards zero and the limits, where the stepper is interesting
    function automatic value_t pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '0;
        if (roll < 35)
            return live_cfg.max_value;
        if (roll < 45)
            return '1;
        if (roll < 55)
            return value_t'($urandom_range(1, 20));
        if (roll < 60)
            return live_cfg.max_value - value_t'($urandom_range(1, 3));
        return value_t'($urandom());
    endfunction

    function automatic button_cfg_t random_cfg();
        button_cfg_t c;
        c.act_low    = 1'($urandom_range(0, 1));
        c.deb_ticks  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                                   : 16'($urandom_range(0, 6));
        c.hold_ticks = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16, 60))
                                                   : 16'($urandom_range(0, 15));
        c.direction  = 2'($urandom_range(0, 3));
        c.max_value  = pick_limit();
        c.step_amt   = pick_limit();
        c.wrap       = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Mostly clean presses of random length, some bounce and some rest
    task automatic send_burst();
        int unsigned kind;
        int unsigned span;
        int unsigned ticks;
        logic        down;
        down = !live_cfg.act_low;
        kind = $urandom_range(0, 99);
        span = int'(live_cfg.deb_ticks) + int'(live_cfg.hold_ticks) + 4;
        if (span > 60)
            span = 60;
        if (kind < 75)
        begin
            ticks = $urandom_range(0, 1) ? span : $urandom_range(0, span);
            repeat (ticks) send_request(down, pick_value());
            repeat ($urandom_range(1, 3)) send_request(!down, pick_value());
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 6)) send_request(1'($urandom_range(0, 1)), pick_value());
        end
        else
        begin
            repeat ($urandom_range(1, 4)) send_request(!down, pick_value());
        end
    endtask

    // Register defaults straight after reset: short presses that never clear debounce
    task automatic test_reset_defaults();
        send_request(1'b0, '0);
        send_request(1'b1, '1);
        send_request(1'b1, 16'h8000);
        send_request(1'b0, 16'h5555);
        send_request(1'b0, 16'haaaa);
    endtask

    // Zero debounce and long times, inverted pin, increment clamped at the top
    task automatic test_thresholds_and_polarity();
        apply_settings(make_cfg(1'b1, '0, '0, bdlp_pkg::DIR_INC, '1, value_t'(1), 1'b0));
        repeat (3) send_request(1'b0, '1);
        send_request(1'b1, '1);
    endtask

    task automatic test_increment_wrap();
        apply_settings(make_cfg(1'b0, '0, '0, bdlp_pkg::DIR_INC, value_t'(100), '1, 1'b1));
        repeat (2) send_request(1'b1, value_t'(50));
        send_request(1'b0, value_t'(50));
    endtask

    // Decrement past zero, from zero with clamp, and from zero with wrap
    task automatic test_decrement_limits();
        apply_settings(make_cfg(1'b0, '0, '0, bdlp_pkg::DIR_DEC, '1, value_t'(10), 1'b0));
        repeat (2) send_request(1'b1, value_t'(3));
        send_request(1'b0, value_t'(3));
        repeat (2) send_request(1'b1, '0);
        send_request(1'b0, '0);
        apply_settings(make_cfg(1'b0, '0, '0, bdlp_pkg::DIR_DEC,
                                value_t'(500), value_t'(10), 1'b1));
        repeat (2) send_request(1'b1, '0);
        send_request(1'b0, '0);
    endtask

    // Spare direction code does nothing; a zero step still flags a change
    task automatic test_direction_and_zero_step();
        apply_settings(make_cfg(1'b0, '0, '0, DIR_UNUSED, '1, value_t'(1), 1'b0));
        repeat (2) send_request(1'b1, value_t'(7));
        send_request(1'b0, value_t'(7));
        apply_settings(make_cfg(1'b0, '0, '0, bdlp_pkg::DIR_INC, '1, '0, 1'b0));
        repeat (2) send_request(1'b1, value_t'(7));
        send_request(1'b0, value_t'(7));
    endtask

    task automatic test_random_presses();
        button_cfg_t c;
        int unsigned start;
        int unsigned quota;
        int unsigned phase_no;
        start    = items_sent;
        phase_no = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // Phase one sits at the top of every register range but the direction
            if (phase_no == 1)
                c = make_cfg(1'b1, '1, '1, bdlp_pkg::DIR_DEC, '1, '1, 1'b1);
            else
                c = random_cfg();
            apply_settings(c);
            steady = (phase_no == 3);
            quota  = items_sent + ((phase_no == 1) ? 15 : $urandom_range(30, 70));
            while (items_sent < quota)
                send_burst();
            phase_no++;
        end
        steady = 1'b0;
    endtask

    // Result side stalls at random except in the steady stretch
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        press_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected result", 0, new_value);
            else
            begin
                want = pending_q.pop_front();
                if (short_press !== want.short_press)
                    report_mismatch("short_press", want.short_press, short_press);
                if (long_press !== want.long_press)
                    report_mismatch("long_press", want.long_press, long_press);
                if (new_value !== want.new_value)
                    report_mismatch("new_value", want.new_value, new_value);
                if (value_changed !== want.value_changed)
                    report_mismatch("value_changed", want.value_changed, value_changed);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles with no request, result or register write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                report_mismatch("no progress, results pending", pending_q.size(), 0);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        live_cfg = make_cfg(1'b0, 16'd50, 16'd1000, bdlp_pkg::DIR_NONE, '1, value_t'(1), 1'b0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_thresholds_and_polarity();
        test_increment_wrap();
        test_decrement_limits();
        test_direction_and_zero_step();
        test_random_presses();

        wait_for_results();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
